>>> rtl/core/smcs_pkg.sv
// Shared types and constants for the sphere mode coefficient solver.
package smcs_pkg;

    localparam int CFG_W   = 31;
    localparam int LANES   = 4;
    localparam int NCELL   = 66;
    localparam int REM_W   = 63;
    localparam int K_W     = 6;

    localparam logic [1:0] CFG_REFRACTIVE_INDEX = 2'd0;
    localparam logic [1:0] CFG_REL_PERMEABILITY = 2'd1;
    localparam logic [1:0] CFG_IMPEDANCE_RATIO  = 2'd2;

    localparam logic [K_W-1:0] NORM_MSB = 6'd30;
    localparam logic [31:0]    SAT_POS  = 32'h7FFF_FFFF;
    localparam logic [31:0]    SAT_NEG  = 32'h8000_0000;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] hankel_re;
        logic signed [31:0] hankel_im;
        logic signed [31:0] dhankel_re;
        logic signed [31:0] dhankel_im;
        logic signed [31:0] bessel_inner;
        logic signed [31:0] bessel_outer;
        logic signed [31:0] dbessel_inner;
        logic signed [31:0] dbessel_outer;
    } smcs_in_t;

    typedef struct packed {
        logic signed [31:0] scatter_re;
        logic signed [31:0] scatter_im;
        logic signed [31:0] internal_re;
        logic signed [31:0] internal_im;
        logic               singular;
        logic               saturated;
    } smcs_out_t;

    // lanes: scatter re, scatter im, internal re, internal im
    typedef struct packed {
        logic                             valid;
        logic                             sing;
        logic                             term_clip;
        logic [K_W-1:0]                   k;
        logic [REM_W-1:0]                 den;
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0]                 ovf;
        logic [LANES-1:0][REM_W-1:0]      rem;
        logic [LANES-1:0][NCELL-1:0]      w;
    } smcs_div_t;

endpackage

>>> rtl/core/smcs_stream_if.sv
// Valid/ready stream channel carrying one item.
interface smcs_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/core/smcs_front.sv
// Front pipeline: scaling, determinant, normalization and numerator products.
module smcs_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  smcs_pkg::smcs_in_t          in_item,
    input  logic [smcs_pkg::CFG_W-1:0]  refr_idx,
    input  logic [smcs_pkg::CFG_W-1:0]  rel_perm,
    input  logic [smcs_pkg::CFG_W-1:0]  imp_ratio,
    output smcs_pkg::smcs_div_t         div_out
);
    import smcs_pkg::*;

    localparam int NSTG = 10;
    localparam logic [CFG_W-1:0]   ONE  = CFG_W'(1) << FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sh1 << (FRAC_BITS - 1);
    localparam logic signed [63:0] QMAX = 64'sh7FFF_FFFF;
    localparam logic signed [63:0] QMIN = -64'sh8000_0000;

    function automatic logic [K_W-1:0] msb_pos(input logic [63:0] v);
        logic [K_W-1:0] p;
        p = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                p = K_W'(i);
        end
        return p;
    endfunction

    logic [NSTG-1:0] vld_reg;

    // stage A
    logic [CFG_W-1:0]   s1, s2;
    logic signed [31:0] s1_s, s2_s;
    logic signed [63:0] pa_next [6];
    logic signed [63:0] pa_reg [6];
    logic signed [31:0] a12a_reg, a22a_reg;

    // stage B
    logic signed [31:0] t_next [6];
    logic signed [31:0] t_reg [6];
    logic               clipb_next, clipb_reg;
    logic signed [31:0] a12b_reg, a22b_reg;
    logic signed [63:0] r64;

    // stage C
    logic signed [63:0] pc_next [10];
    logic signed [63:0] pc_reg [10];
    logic               clipc_reg;

    // stage D
    logic signed [63:0] dd_next [5];
    logic signed [63:0] dd_reg [5];
    logic               clipd_reg;

    // stage E
    logic [63:0]        mag_next [5];
    logic [63:0]        mag_reg [5];
    logic [4:0]         sgn_reg;
    logic               singe_reg, clipe_reg;

    // stage F
    logic [K_W-1:0]     msb, k_next;
    logic [30:0]        dm_next [2];
    logic [30:0]        dm_reg [2];
    logic [63:0]        nm_reg [3];
    logic [4:0]         sgnf_reg;
    logic [K_W-1:0]     kf_reg;
    logic               singf_reg, clipf_reg;
    logic [63:0]        dsh [2];

    // stage G
    logic [62:0]        ppl_next [6];
    logic [62:0]        pph_next [6];
    logic [62:0]        ppl_reg [6];
    logic [62:0]        pph_reg [6];
    logic [5:0]         psg_next, psg_reg;
    logic [61:0]        sq_next [2];
    logic [61:0]        sq_reg [2];
    logic [K_W-1:0]     kg_reg;
    logic               sing_g_reg, clipg_reg;

    // stage H1
    logic [94:0]        m95;
    logic signed [96:0] sp_next [6];
    logic signed [96:0] sp_reg [6];
    logic [REM_W-1:0]   denh_reg;
    logic [K_W-1:0]     kh_reg;
    logic               singh_reg, cliph_reg;

    // stage H2
    logic signed [96:0] ln_next [LANES];
    logic signed [96:0] ln_reg [LANES];
    logic [REM_W-1:0]   den2_reg;
    logic [K_W-1:0]     k2_reg;
    logic               sing2_reg, clip2_reg;

    // stage I
    logic [95:0]        mi_next [LANES];
    logic [95:0]        mi_reg [LANES];
    logic [LANES-1:0]   negi_reg;
    logic [REM_W-1:0]   deni_reg;
    logic [K_W-1:0]     ki_reg;
    logic               singi_reg, clipi_reg;

    // stage J
    logic [127:0]       nsh;
    smcs_div_t          div_next, div_reg;

    always_comb
    begin
        s1   = in_item.mode ? ONE : imp_ratio;
        s2   = in_item.mode ? rel_perm : refr_idx;
        s1_s = $signed({1'b0, s1});
        s2_s = $signed({1'b0, s2});
        pa_next[0] = 64'(in_item.hankel_re) * 64'(s1_s);
        pa_next[1] = 64'(in_item.hankel_im) * 64'(s1_s);
        pa_next[2] = 64'(in_item.dhankel_re) * 64'(s2_s);
        pa_next[3] = 64'(in_item.dhankel_im) * 64'(s2_s);
        pa_next[4] = 64'(in_item.bessel_outer) * 64'(s1_s);
        pa_next[5] = 64'(in_item.dbessel_outer) * 64'(s2_s);
    end

    always_comb
    begin
        clipb_next = 1'b0;
        r64 = '0;
        for (int i = 0; i < 6; i++)
        begin
            r64 = (pa_reg[i] + HALF) >>> FRAC_BITS;
            if (r64 > QMAX)
            begin
                t_next[i]  = 32'sh7FFF_FFFF;
                clipb_next = 1'b1;
            end
            else if (r64 < QMIN)
            begin
                t_next[i]  = -32'sh8000_0000;
                clipb_next = 1'b1;
            end
            else
            begin
                t_next[i] = r64[31:0];
            end
        end
    end

    // t: 0 a11r, 1 a11i, 2 a21r, 3 a21i, 4 b1, 5 b2
    always_comb
    begin
        pc_next[0] = 64'(t_reg[0]) * 64'(a22b_reg);
        pc_next[1] = 64'(t_reg[2]) * 64'(a12b_reg);
        pc_next[2] = 64'(t_reg[1]) * 64'(a22b_reg);
        pc_next[3] = 64'(t_reg[3]) * 64'(a12b_reg);
        pc_next[4] = 64'(t_reg[4]) * 64'(a22b_reg);
        pc_next[5] = 64'(t_reg[5]) * 64'(a12b_reg);
        pc_next[6] = 64'(t_reg[0]) * 64'(t_reg[5]);
        pc_next[7] = 64'(t_reg[2]) * 64'(t_reg[4]);
        pc_next[8] = 64'(t_reg[1]) * 64'(t_reg[5]);
        pc_next[9] = 64'(t_reg[3]) * 64'(t_reg[4]);
    end

    // dd: 0 det re, 1 det im, 2 scatter num, 3 internal num re, 4 internal num im
    always_comb
    begin
        for (int j = 0; j < 5; j++)
        begin
            dd_next[j]  = pc_reg[2*j] - pc_reg[2*j+1];
            mag_next[j] = dd_reg[j][63] ? 64'(-dd_reg[j]) : 64'(dd_reg[j]);
        end
    end

    always_comb
    begin
        msb    = msb_pos(mag_reg[0] | mag_reg[1]);
        k_next = (msb > NORM_MSB) ? (msb - NORM_MSB) : '0;
        for (int d = 0; d < 2; d++)
        begin
            dsh[d]     = mag_reg[d] >> k_next;
            dm_next[d] = dsh[d][30:0];
        end
    end

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            for (int d = 0; d < 2; d++)
            begin
                ppl_next[2*n+d] = 63'(nm_reg[n][31:0]) * 63'(dm_reg[d]);
                pph_next[2*n+d] = 63'(nm_reg[n][63:32]) * 63'(dm_reg[d]);
                psg_next[2*n+d] = sgnf_reg[n+2] ^ sgnf_reg[d];
            end
        end
        for (int d = 0; d < 2; d++)
            sq_next[d] = 62'(dm_reg[d]) * 62'(dm_reg[d]);
    end

    always_comb
    begin
        m95 = '0;
        for (int p = 0; p < 6; p++)
        begin
            m95 = (95'(pph_reg[p]) << 32) + 95'(ppl_reg[p]);
            sp_next[p] = psg_reg[p] ? -$signed({2'b0, m95}) : $signed({2'b0, m95});
        end
    end

    always_comb
    begin
        ln_next[0] = sp_reg[0];
        ln_next[1] = -sp_reg[1];
        ln_next[2] = sp_reg[2] + sp_reg[5];
        ln_next[3] = sp_reg[4] - sp_reg[3];
        for (int l = 0; l < LANES; l++)
            mi_next[l] = ln_reg[l][96] ? 96'(-ln_reg[l]) : 96'(ln_reg[l]);
    end

    always_comb
    begin
        div_next           = '0;
        div_next.valid     = vld_reg[NSTG-1];
        div_next.sing      = singi_reg;
        div_next.term_clip = clipi_reg;
        div_next.k         = ki_reg;
        div_next.den       = deni_reg;
        div_next.neg       = negi_reg;
        nsh = '0;
        for (int l = 0; l < LANES; l++)
        begin
            nsh             = 128'(mi_reg[l]) << (FRAC_BITS + 1);
            div_next.ovf[l] = {1'b0, nsh[127:NCELL]} >= deni_reg;
            div_next.rem[l] = {1'b0, nsh[127:NCELL]};
            div_next.w[l]   = nsh[NCELL-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            div_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
            div_reg <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg   <= pa_next;
            a12a_reg <= in_item.bessel_inner;
            a22a_reg <= in_item.dbessel_inner;

            t_reg     <= t_next;
            clipb_reg <= clipb_next;
            a12b_reg  <= a12a_reg;
            a22b_reg  <= a22a_reg;

            pc_reg    <= pc_next;
            clipc_reg <= clipb_reg;

            dd_reg    <= dd_next;
            clipd_reg <= clipc_reg;

            mag_reg   <= mag_next;
            for (int j = 0; j < 5; j++)
                sgn_reg[j] <= dd_reg[j][63];
            singe_reg <= (dd_reg[0] == '0) && (dd_reg[1] == '0);
            clipe_reg <= clipd_reg;

            dm_reg    <= dm_next;
            nm_reg[0] <= mag_reg[2];
            nm_reg[1] <= mag_reg[3];
            nm_reg[2] <= mag_reg[4];
            sgnf_reg  <= sgn_reg;
            kf_reg    <= k_next;
            singf_reg <= singe_reg;
            clipf_reg <= clipe_reg;

            ppl_reg    <= ppl_next;
            pph_reg    <= pph_next;
            psg_reg    <= psg_next;
            sq_reg     <= sq_next;
            kg_reg     <= kf_reg;
            sing_g_reg <= singf_reg;
            clipg_reg  <= clipf_reg;

            sp_reg    <= sp_next;
            denh_reg  <= REM_W'(sq_reg[0]) + REM_W'(sq_reg[1]);
            kh_reg    <= kg_reg;
            singh_reg <= sing_g_reg;
            cliph_reg <= clipg_reg;

            ln_reg    <= ln_next;
            den2_reg  <= denh_reg;
            k2_reg    <= kh_reg;
            sing2_reg <= singh_reg;
            clip2_reg <= cliph_reg;

            mi_reg    <= mi_next;
            for (int l = 0; l < LANES; l++)
                negi_reg[l] <= ln_reg[l][96];
            deni_reg  <= den2_reg;
            ki_reg    <= k2_reg;
            singi_reg <= sing2_reg;
            clipi_reg <= clip2_reg;
        end
    end

    assign div_out = div_reg;

endmodule

>>> rtl/core/smcs_div_cell.sv
// One restoring-division cell: one quotient bit for each of the four lanes.
module smcs_div_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  smcs_pkg::smcs_div_t  div_in,
    output smcs_pkg::smcs_div_t  div_out
);
    import smcs_pkg::*;

    smcs_div_t        div_next, div_reg;
    logic [REM_W:0]   t;
    logic             ge;

    always_comb
    begin
        div_next = div_in;
        t  = '0;
        ge = 1'b0;
        for (int l = 0; l < LANES; l++)
        begin
            t  = {div_in.rem[l], div_in.w[l][NCELL-1]};
            ge = t >= {1'b0, div_in.den};
            div_next.rem[l] = ge ? REM_W'(t - {1'b0, div_in.den}) : t[REM_W-1:0];
            div_next.w[l]   = {div_in.w[l][NCELL-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_reg <= '0;
        else if (en)
            div_reg <= div_next;
    end

    assign div_out = div_reg;

endmodule

>>> rtl/core/smcs_finish.sv
// Rounding, sign restore and saturation of the four quotients.
module smcs_finish (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  smcs_pkg::smcs_div_t  div_in,
    output logic                 fin_valid,
    output smcs_pkg::smcs_out_t  fin_item
);
    import smcs_pkg::*;

    logic [NCELL:0]     sum, r, lim;
    logic [6:0]         sh;
    logic [31:0]        m32;
    logic [31:0]        val [LANES];
    logic [LANES-1:0]   cl;
    smcs_out_t          fin_next, fin_reg;
    logic               vld_reg;

    always_comb
    begin
        sh  = 7'(div_in.k) + 7'd1;
        sum = '0;
        r   = '0;
        lim = '0;
        m32 = '0;
        for (int l = 0; l < LANES; l++)
        begin
            sum   = (NCELL+1)'(div_in.w[l]) + ((NCELL+1)'(1) << div_in.k);
            r     = sum >> sh;
            lim   = div_in.neg[l] ? (NCELL+1)'(SAT_NEG) : (NCELL+1)'(SAT_POS);
            cl[l] = div_in.ovf[l] || (r > lim);
            m32   = cl[l] ? lim[31:0] : r[31:0];
            val[l] = div_in.sing ? '0 : (div_in.neg[l] ? -m32 : m32);
        end
        fin_next.scatter_re  = val[0];
        fin_next.scatter_im  = val[1];
        fin_next.internal_re = val[2];
        fin_next.internal_im = val[3];
        fin_next.singular    = div_in.sing;
        fin_next.saturated   = div_in.term_clip | (!div_in.sing & (|cl));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= div_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fin_reg <= fin_next;
    end

    assign fin_valid = vld_reg;
    assign fin_item  = fin_reg;

endmodule

>>> rtl/core/sphere_mode_coefficient_solver_unit.sv
// Sphere mode coefficient solver: Cramer's rule on a 2x2 complex system.
// Pipeline: 11 front stages covering scaling, determinant, normalize and divide
// setup, 66 division cells, one rounding stage, output buffer. Throughput: one
// item per cycle unless the output buffer is full and coeffs.ready is low; a
// 2-entry output buffer lets the pipe keep moving while one result waits. Reset
// clears all valid bits and loads 1.0 into the three scale registers.
module sphere_mode_coefficient_solver_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [smcs_pkg::CFG_W-1:0]  cfg_data,
    smcs_stream_if.sink                 operands,
    smcs_stream_if.source               coeffs
);
    import smcs_pkg::*;

    localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

    logic [CFG_W-1:0] refr_idx_reg, rel_perm_reg, imp_ratio_reg;
    logic             en;
    smcs_div_t        chain [NCELL+1];
    logic             fin_valid;
    smcs_out_t        fin_item;

    smcs_out_t        buf_reg [2];
    logic             wr_reg, rd_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refr_idx_reg  <= ONE;
            rel_perm_reg  <= ONE;
            imp_ratio_reg <= ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REFRACTIVE_INDEX: refr_idx_reg  <= cfg_data;
                CFG_REL_PERMEABILITY: rel_perm_reg  <= cfg_data;
                CFG_IMPEDANCE_RATIO:  imp_ratio_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en             = (cnt_reg != 2'd2) || coeffs.ready;
    assign operands.ready = en;

    smcs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (operands.valid),
        .in_item   (operands.payload),
        .refr_idx  (refr_idx_reg),
        .rel_perm  (rel_perm_reg),
        .imp_ratio (imp_ratio_reg),
        .div_out   (chain[0])
    );

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        smcs_div_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .div_in  (chain[i]),
            .div_out (chain[i+1])
        );
    end

    smcs_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .div_in    (chain[NCELL]),
        .fin_valid (fin_valid),
        .fin_item  (fin_item)
    );

    assign push = en && fin_valid;
    assign pop  = coeffs.valid && coeffs.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_reg] <= fin_item;
    end

    assign coeffs.valid   = cnt_reg != 2'd0;
    assign coeffs.payload = buf_reg[rd_reg];

endmodule

>>> test/testbench.sv
// Self-checking testbench for the sphere mode coefficient solver unit.
module testbench;
    import smcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int LATENCY_WAIT = 90;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PER_PHASE = 165;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    smcs_stream_if #(.item_t(smcs_in_t)) operands ();
    smcs_stream_if #(.item_t(smcs_out_t)) coeffs ();

    sphere_mode_coefficient_solver_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .operands(operands.sink),
        .coeffs(coeffs.source)
    );

    always #1 clk = ~clk;

    logic [30:0] index_n = 31'h10000;
    logic [30:0] perm_mu = 31'h10000;
    logic [30:0] imp_z = 31'h10000;

    smcs_in_t pending_items[$];
    smcs_out_t expected_coeffs[$];
    int errors = 0;
    int items_in = 0;
    int results_out = 0;
    int singular_seen = 0;
    int saturated_seen = 0;
    int idle_cycles = 0;
    bit took = 0;
    bit no_idle = 0;
    bit hold_req = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_cnt = 0;

    function automatic longint scale_term(longint x, longint s, inout bit clip);
        longint r;
        r = (x * s + 64'sd32768) >>> 16;
        if (r > 64'sh7FFFFFFF) begin
            clip = 1;
            r = 64'sh7FFFFFFF;
        end
        if (r < -64'sh80000000) begin
            clip = 1;
            r = -64'sh80000000;
        end
        return r;
    endfunction

    function automatic logic [31:0] round_quot(logic signed [127:0] num,
                                               longint unsigned den, int k, inout bit clip);
        logic neg;
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] limit;
        neg = num[127];
        mag = neg ? -num : num;
        q = mag / {64'd0, den};
        q = (q + (128'd1 << k)) >> (k + 1);
        limit = neg ? 128'h80000000 : 128'h7FFFFFFF;
        if (q > limit) begin
            clip = 1;
            q = limit;
        end
        return neg ? 32'(0 - q[31:0]) : q[31:0];
    endfunction

    function automatic smcs_out_t solve_mode(smcs_in_t it);
        smcs_out_t r;
        bit clip;
        longint s1, s2, a11r, a11i, a21r, a21i, a12, a22, b1, b2;
        longint detr, deti, ns, nir, nii, dr, di;
        longint unsigned mr, mi, m, den;
        logic signed [127:0] wdr, wdi, wns, wnr, wni, re, im;
        int k;
        clip = 0;
        s1 = it.mode ? 64'sh10000 : longint'(imp_z);
        s2 = it.mode ? longint'(perm_mu) : longint'(index_n);
        a11r = scale_term(longint'(it.hankel_re), s1, clip);
        a11i = scale_term(longint'(it.hankel_im), s1, clip);
        a21r = scale_term(longint'(it.dhankel_re), s2, clip);
        a21i = scale_term(longint'(it.dhankel_im), s2, clip);
        a12 = longint'(it.bessel_inner);
        b1 = scale_term(longint'(it.bessel_outer), s1, clip);
        a22 = longint'(it.dbessel_inner);
        b2 = scale_term(longint'(it.dbessel_outer), s2, clip);
        detr = a11r * a22 - a21r * a12;
        deti = a11i * a22 - a21i * a12;
        ns = b1 * a22 - b2 * a12;
        nir = a11r * b2 - a21r * b1;
        nii = a11i * b2 - a21i * b1;
        r = '0;
        r.singular = (detr == 0 && deti == 0);
        if (!r.singular) begin
            mr = detr < 0 ? -detr : detr;
            mi = deti < 0 ? -deti : deti;
            m = mr > mi ? mr : mi;
            k = 0;
            while ((m >> k) >= 64'h80000000)
                k++;
            dr = longint'(mr >> k);
            di = longint'(mi >> k);
            if (detr < 0) dr = -dr;
            if (deti < 0) di = -di;
            den = longint'(dr * dr) + longint'(di * di);
            wdr = 128'(dr);
            wdi = 128'(di);
            wns = 128'(ns);
            wnr = 128'(nir);
            wni = 128'(nii);
            re = wns * wdr;
            im = -(wns * wdi);
            r.scatter_re = round_quot(re <<< 17, den, k, clip);
            r.scatter_im = round_quot(im <<< 17, den, k, clip);
            re = wnr * wdr + wni * wdi;
            im = wni * wdr - wnr * wdi;
            r.internal_re = round_quot(re <<< 17, den, k, clip);
            r.internal_im = round_quot(im <<< 17, den, k, clip);
        end
        r.saturated = clip;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] field_value();
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 4))
                   0: return 32'h0;
                   1: return 32'h1;
                   2: return 32'hFFFF_FFFF;
                   3: return SAT_POS;
                   default: return SAT_NEG;
               endcase
            1, 2: return $urandom;
            default: return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
        endcase
    endfunction

    function automatic smcs_in_t random_item();
        smcs_in_t it;
        it.mode = 1'($urandom_range(0, 1));
        it.hankel_re = field_value();
        it.hankel_im = field_value();
        it.dhankel_re = field_value();
        it.dhankel_im = field_value();
        it.bessel_inner = field_value();
        it.bessel_outer = field_value();
        it.dbessel_inner = field_value();
        it.dbessel_outer = field_value();
        if ($urandom_range(0, 11) == 0) begin
            it.bessel_inner = 0;
            it.dbessel_inner = 0;
        end else if ($urandom_range(0, 11) == 0) begin
            it.bessel_inner = 0;
            it.hankel_re = 0;
            it.hankel_im = 0;
        end
        return it;
    endfunction

    function automatic smcs_in_t fill_item(logic m, logic [31:0] v);
        smcs_in_t it;
        it.mode = m;
        it.hankel_re = v;
        it.hankel_im = v;
        it.dhankel_re = v;
        it.dhankel_im = v;
        it.bessel_inner = v;
        it.bessel_outer = v;
        it.dbessel_inner = v;
        it.dbessel_outer = v;
        return it;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t mismatch %s: expected %h, actual %h", $realtime, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            idle_cycles++;
            if (operands.valid && operands.ready) begin
                expected_coeffs.push_back(solve_mode(operands.payload));
                took = 1;
                items_in++;
                idle_cycles = 0;
            end
            if (coeffs.valid && coeffs.ready) begin
                idle_cycles = 0;
                results_out++;
                if (expected_coeffs.size() == 0) begin
                    $display("%0t unexpected item: actual %h", $realtime, coeffs.payload);
                    errors++;
                end else begin
                    smcs_out_t e;
                    e = expected_coeffs.pop_front();
                    check_field("scatter_re", e.scatter_re, coeffs.payload.scatter_re);
                    check_field("scatter_im", e.scatter_im, coeffs.payload.scatter_im);
                    check_field("internal_re", e.internal_re, coeffs.payload.internal_re);
                    check_field("internal_im", e.internal_im, coeffs.payload.internal_im);
                    check_field("singular", 32'(e.singular), 32'(coeffs.payload.singular));
                    check_field("saturated", 32'(e.saturated), 32'(coeffs.payload.saturated));
                    singular_seen += int'(e.singular);
                    saturated_seen += int'(e.saturated);
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        operands.valid = 1'b0;
        operands.payload = '0;
        coeffs.ready = 1'b0;
    end

    always @(negedge clk) begin
        if (rst_n && (!operands.valid || took)) begin
            took = 0;
            if (send_gap > 0) begin
                send_gap--;
                operands.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                operands.payload <= pending_items.pop_front();
                operands.valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                operands.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_cnt > 0) begin
                hold_cnt--;
                coeffs.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 0;
                hold_cnt = 400;
                coeffs.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                coeffs.ready <= 1'b0;
            end else begin
                coeffs.ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_REFRACTIVE_INDEX: index_n = val;
            CFG_REL_PERMEABILITY: perm_mu = val;
            CFG_IMPEDANCE_RATIO: imp_z = val;
            default: ;
        endcase
    endtask

    task automatic set_scales(logic [30:0] n, logic [30:0] mu, logic [30:0] z);
        write_reg(CFG_REFRACTIVE_INDEX, n);
        write_reg(CFG_REL_PERMEABILITY, mu);
        write_reg(CFG_IMPEDANCE_RATIO, z);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || operands.valid || expected_coeffs.size() > 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic push_directed();
        smcs_in_t it;
        for (int m = 0; m < 2; m++) begin
            pending_items.push_back(fill_item(1'(m), 32'h0));
            pending_items.push_back(fill_item(1'(m), SAT_POS));
            pending_items.push_back(fill_item(1'(m), SAT_NEG));
            pending_items.push_back(fill_item(1'(m), 32'hFFFF_FFFF));
            pending_items.push_back(fill_item(1'(m), 32'h0001_0000));
            it = fill_item(1'(m), 32'h0001_0000);
            it.hankel_im = SAT_NEG;
            it.dbessel_inner = SAT_POS;
            it.bessel_outer = SAT_POS;
            it.bessel_inner = 32'h1;
            pending_items.push_back(it);
            it = fill_item(1'(m), 32'h0);
            it.hankel_re = 32'h1;
            it.dbessel_inner = 32'h1;
            it.bessel_outer = SAT_POS;
            pending_items.push_back(it);
            it = fill_item(1'(m), 32'h0002_8000);
            it.bessel_inner = 32'h0;
            pending_items.push_back(it);
        end
    endtask

    task automatic push_random(int n);
        repeat (n) pending_items.push_back(random_item());
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_directed();
        push_random(RANDOM_PER_PHASE);
        drain();

        set_scales(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        write_reg(CFG_SPARE, 31'h0);
        push_directed();
        hold_req = 1;
        push_random(RANDOM_PER_PHASE);
        drain();

        set_scales(31'h0, 31'h0, 31'h0);
        push_random(RANDOM_PER_PHASE / 2);
        drain();

        no_idle = 1;
        set_scales(31'($urandom_range(1, 31'h4_0000)), 31'($urandom_range(1, 31'h4_0000)),
                   31'($urandom_range(1, 31'h4_0000)));
        push_random(RANDOM_PER_PHASE);
        drain();
        no_idle = 0;

        set_scales(31'($urandom), 31'($urandom), 31'($urandom));
        push_random(RANDOM_PER_PHASE);
        drain();

        set_scales(31'h1_8000, 31'h1_0000, 31'h0_D000);
        hold_req = 1;
        push_random(RANDOM_PER_PHASE);
        drain();

        $display("run: %0d items in, %0d results out over six scale settings", items_in,
                 results_out);
        $display("run: %0d singular and %0d saturated results", singular_seen, saturated_seen);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
